// ----- rtl/core/ffcp_pkg.sv -----
// Shared types and constants for the force-feedback command parser.
// No dependencies; used by force_feedback_command_parser.
package ffcp_pkg;

	// Fixed field widths of the byte stream and of the result
	localparam int unsigned BYTE_BITS    = 8;
	localparam int unsigned OUT_VAL_BITS = 16;
	localparam int unsigned NUM_FINGERS  = 5;
	localparam int unsigned FINGER_BITS  = 3;
	localparam int unsigned KLEN_BITS    = 2;

	// Character codes
	localparam logic [BYTE_BITS-1:0] CHAR_ZERO = 8'h30;
	localparam logic [BYTE_BITS-1:0] CHAR_NINE = 8'h39;
	localparam logic [BYTE_BITS-1:0] CHAR_A    = 8'h41;
	localparam logic [BYTE_BITS-1:0] CHAR_E    = 8'h45;

	// Key finger code that marks a key which is not a finger
	localparam logic [FINGER_BITS-1:0] NO_FINGER = 3'd7;

	// Key length saturates here
	localparam logic [KLEN_BITS-1:0] KLEN_MAX = 2'd2;

	typedef logic [FINGER_BITS-1:0]  finger_t;
	typedef logic [NUM_FINGERS-1:0]  finger_mask_t;
	typedef logic [OUT_VAL_BITS-1:0] out_val_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NO_FINGER = 2'd1,
		STATUS_EMPTY_KEY = 2'd2
	} status_t;

endpackage

// ----- rtl/core/ffcp_digit_acc.sv -----
// Saturating decimal accumulate step: acc * 10 + digit, clipped to all ones.
// Depends on ffcp_pkg for nothing but stays parameterized on the value width.
module ffcp_digit_acc #(
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic [VALUE_BITS-1:0] acc,
	input  logic [3:0]            digit,
	output logic [VALUE_BITS-1:0] acc_next
);

	localparam int unsigned WIDE_BITS = VALUE_BITS + 4;

	logic [WIDE_BITS-1:0] acc_wide;
	logic [WIDE_BITS-1:0] prod;

	// Times ten as (x << 3) + (x << 1), then add the digit
	assign acc_wide = WIDE_BITS'(acc);
	assign prod     = (acc_wide << 3) + (acc_wide << 1) + WIDE_BITS'(digit);

	// Clip when any bit above the value width is set
	assign acc_next = (prod[WIDE_BITS-1:VALUE_BITS] != '0) ? {VALUE_BITS{1'b1}}
	                                                         : prod[VALUE_BITS-1:0];

endmodule

// ----- rtl/core/force_feedback_command_parser.sv -----
// Force-feedback command parser: one message byte per cycle in, one result per message.
// Latency: the result is valid in the cycle after the last byte's transaction.
// Throughput: one byte per cycle; the parse update is a single registered pass,
// stalled only while a finished result waits in the output register.
// Reset: arst_n clears all parse state and the output valid; after each result
// the parse state returns to that reset state for the next message.
module force_feedback_command_parser #(
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_message
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [15:0] thumb_value, [31:16] index_value,
	                               // [47:32] middle_value, [63:48] ring_value,
	                               // [79:64] pinky_value, [84:80] present_mask, [87:85] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int unsigned NF = ffcp_pkg::NUM_FINGERS;

	// Parse state
	logic                        prev_digit_q;
	logic                        seen_digit_q;
	logic [ffcp_pkg::KLEN_BITS-1:0] key_len_q;
	ffcp_pkg::finger_t           key_finger_q;
	logic [VALUE_BITS-1:0]       acc_q;
	logic [VALUE_BITS-1:0]       values_q [NF];
	ffcp_pkg::finger_mask_t      present_q;
	logic                        empty_err_q;

	// Output register
	logic                        out_valid_q;
	ffcp_pkg::out_val_t          out_vals_q [NF];
	ffcp_pkg::finger_mask_t      out_mask_q;
	ffcp_pkg::status_t           out_status_q;

	logic                        in_xfer;
	logic                        is_digit;
	logic                        do_close;
	logic [VALUE_BITS-1:0]       acc_step;

	// After closing the previous command
	logic                        seen_c;
	logic [ffcp_pkg::KLEN_BITS-1:0] key_len_c;
	ffcp_pkg::finger_t           key_finger_c;
	logic [VALUE_BITS-1:0]       values_c [NF];
	ffcp_pkg::finger_mask_t      present_c;
	logic                        empty_err_c;

	// After consuming the byte
	logic                        seen_n;
	logic [ffcp_pkg::KLEN_BITS-1:0] key_len_n;
	ffcp_pkg::finger_t           key_finger_n;
	logic [VALUE_BITS-1:0]       acc_n;

	// After the final close on the last byte
	logic [VALUE_BITS-1:0]       values_f [NF];
	ffcp_pkg::finger_mask_t      present_f;
	logic                        empty_err_f;
	ffcp_pkg::status_t           status_f;

	assign s_tready = !out_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;
	assign is_digit = (s_tdata >= ffcp_pkg::CHAR_ZERO) && (s_tdata <= ffcp_pkg::CHAR_NINE);
	assign do_close = !is_digit && prev_digit_q;

	ffcp_digit_acc #(
		.VALUE_BITS(VALUE_BITS)
	) u_digit_acc (
		.acc      (acc_q),
		.digit    (4'(s_tdata - ffcp_pkg::CHAR_ZERO)),
		.acc_next (acc_step)
	);

	// Close the running command when a non-digit follows a digit
	always_comb begin
		seen_c       = do_close ? 1'b0 : seen_digit_q;
		key_len_c    = do_close ? '0 : key_len_q;
		key_finger_c = do_close ? ffcp_pkg::NO_FINGER : key_finger_q;
		present_c    = present_q;
		empty_err_c  = empty_err_q;
		for (int i = 0; i < NF; i++) begin
			values_c[i] = values_q[i];
			if (do_close && key_finger_q == ffcp_pkg::finger_t'(i)) begin
				present_c[i] = 1'b1;
				if (seen_digit_q) begin
					values_c[i] = acc_q;
				end else begin
					empty_err_c = 1'b1;
				end
			end
		end
	end

	// Consume the byte: extend the digit run or the key
	always_comb begin
		seen_n       = seen_c;
		key_len_n    = key_len_c;
		key_finger_n = key_finger_c;
		acc_n        = do_close ? '0 : acc_q;
		if (is_digit) begin
			seen_n = 1'b1;
			acc_n  = acc_step;
		end else if (!seen_c) begin
			if (key_len_c == '0 && s_tdata >= ffcp_pkg::CHAR_A
			    && s_tdata <= ffcp_pkg::CHAR_E) begin
				key_finger_n = ffcp_pkg::finger_t'(s_tdata - ffcp_pkg::CHAR_A);
			end else begin
				key_finger_n = ffcp_pkg::NO_FINGER;
			end
			if (key_len_c < ffcp_pkg::KLEN_MAX) begin
				key_len_n = key_len_c + ffcp_pkg::KLEN_BITS'(1);
			end
		end
	end

	// Final close and status on the last byte
	always_comb begin
		present_f   = present_c;
		empty_err_f = empty_err_c;
		for (int i = 0; i < NF; i++) begin
			values_f[i] = values_c[i];
			if (key_finger_n == ffcp_pkg::finger_t'(i)) begin
				present_f[i] = 1'b1;
				if (seen_n) begin
					values_f[i] = acc_n;
				end else begin
					empty_err_f = 1'b1;
				end
			end
		end
		if (present_f == '0) begin
			status_f = ffcp_pkg::STATUS_NO_FINGER;
		end else if (empty_err_f) begin
			status_f = ffcp_pkg::STATUS_EMPTY_KEY;
		end else begin
			status_f = ffcp_pkg::STATUS_OK;
		end
	end

	// Advance parse state; return to reset state after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_digit_q <= 1'b0;
			seen_digit_q <= 1'b0;
			key_len_q    <= '0;
			key_finger_q <= ffcp_pkg::NO_FINGER;
			acc_q        <= '0;
			present_q    <= '0;
			empty_err_q  <= 1'b0;
			for (int i = 0; i < NF; i++) begin
				values_q[i] <= '0;
			end
		end else if (in_xfer) begin
			if (s_tlast) begin
				prev_digit_q <= 1'b0;
				seen_digit_q <= 1'b0;
				key_len_q    <= '0;
				key_finger_q <= ffcp_pkg::NO_FINGER;
				acc_q        <= '0;
				present_q    <= '0;
				empty_err_q  <= 1'b0;
				for (int i = 0; i < NF; i++) begin
					values_q[i] <= '0;
				end
			end else begin
				prev_digit_q <= is_digit;
				seen_digit_q <= seen_n;
				key_len_q    <= key_len_n;
				key_finger_q <= key_finger_n;
				acc_q        <= acc_n;
				present_q    <= present_c;
				empty_err_q  <= empty_err_c;
				for (int i = 0; i < NF; i++) begin
					values_q[i] <= values_c[i];
				end
			end
		end
	end

	// Output valid: set on the last byte, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer && s_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load result payload; values show only when status is ok
	always_ff @(posedge clk) begin
		if (in_xfer && s_tlast) begin
			out_mask_q   <= present_f;
			out_status_q <= status_f;
			for (int i = 0; i < NF; i++) begin
				out_vals_q[i] <= (status_f == ffcp_pkg::STATUS_OK)
				                 ? ffcp_pkg::OUT_VAL_BITS'(values_f[i]) : '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_mask_q, out_vals_q[4], out_vals_q[3],
	                   out_vals_q[2], out_vals_q[1], out_vals_q[0]};
	assign m_tuser  = out_status_q;

endmodule
